>>> hw/rtl/segmentation_template_labeler_core_defines.svh
// Assertion macros used by the checker.
`ifndef SEGMENTATION_TEMPLATE_LABELER_CORE_DEFINES_SVH
`define SEGMENTATION_TEMPLATE_LABELER_CORE_DEFINES_SVH

// Same-cycle implication.
`define STL_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/stl_pkg.sv
package stl_pkg;

    localparam int COORD_BITS = 12;
    localparam int POS_W      = COORD_BITS + 1;
    localparam int ORG_W      = COORD_BITS;
    localparam int SIZE_W     = COORD_BITS + 1;
    localparam int MUL_W      = 2 * SIZE_W;
    localparam int KEY_W      = MUL_W + 3;
    localparam int CMP_W      = KEY_W + 3;
    localparam int TPL_W      = 5;
    localparam int LABEL_W    = 8;
    localparam int REGION_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [CFG_IDX_W-1:0] REG_AREA_LEFT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_TOP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_INDEX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_REGION0  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_REGION1  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_REGION2  = 3'd7;

    localparam logic [LABEL_W-1:0]  LABEL_OUTSIDE = 8'hFF;
    localparam logic [REGION_W-1:0] REGION_0 = 2'd0;
    localparam logic [REGION_W-1:0] REGION_1 = 2'd1;
    localparam logic [REGION_W-1:0] REGION_2 = 2'd2;

    localparam logic [TPL_W-1:0] TPL_UNIFORM   = 5'd0;
    localparam logic [TPL_W-1:0] TPL_THIRDS_H  = 5'd1;
    localparam logic [TPL_W-1:0] TPL_THIRDS_V  = 5'd2;
    localparam logic [TPL_W-1:0] TPL_DIAG_ANTI = 5'd3;
    localparam logic [TPL_W-1:0] TPL_DIAG_MAIN = 5'd4;
    localparam logic [TPL_W-1:0] TPL_BOX       = 5'd5;
    localparam logic [TPL_W-1:0] TPL_V_0       = 5'd6;
    localparam logic [TPL_W-1:0] TPL_V_1       = 5'd7;
    localparam logic [TPL_W-1:0] TPL_V_2       = 5'd8;
    localparam logic [TPL_W-1:0] TPL_V_3       = 5'd9;
    localparam logic [TPL_W-1:0] TPL_BAND_0    = 5'd10;
    localparam logic [TPL_W-1:0] TPL_BAND_1    = 5'd11;
    localparam logic [TPL_W-1:0] TPL_BAND_2    = 5'd12;
    localparam logic [TPL_W-1:0] TPL_BAND_3    = 5'd13;
    localparam logic [TPL_W-1:0] TPL_TH_0      = 5'd14;
    localparam logic [TPL_W-1:0] TPL_TH_1      = 5'd15;
    localparam logic [TPL_W-1:0] TPL_TH_2      = 5'd16;
    localparam logic [TPL_W-1:0] TPL_TH_3      = 5'd17;
    localparam logic [TPL_W-1:0] TPL_Y_0       = 5'd18;
    localparam logic [TPL_W-1:0] TPL_Y_1       = 5'd19;
    localparam logic [TPL_W-1:0] TPL_Y_2       = 5'd20;
    localparam logic [TPL_W-1:0] TPL_Y_3       = 5'd21;
    localparam logic [TPL_W-1:0] TPL_TT_0      = 5'd22;
    localparam logic [TPL_W-1:0] TPL_TT_1      = 5'd23;
    localparam logic [TPL_W-1:0] TPL_TT_2      = 5'd24;
    localparam logic [TPL_W-1:0] TPL_TT_3      = 5'd25;
    localparam logic [TPL_W-1:0] TPL_TQ_0      = 5'd26;
    localparam logic [TPL_W-1:0] TPL_TQ_1      = 5'd27;
    localparam logic [TPL_W-1:0] TPL_TQ_2      = 5'd28;
    localparam logic [TPL_W-1:0] TPL_TQ_3      = 5'd29;

    typedef struct packed {
        logic [ORG_W-1:0]   left;
        logic [ORG_W-1:0]   top;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [TPL_W-1:0]   tpl;
        logic [LABEL_W-1:0] lab0;
        logic [LABEL_W-1:0] lab1;
        logic [LABEL_W-1:0] lab2;
    } cfg_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] k1;
        logic signed [KEY_W-1:0] k2;
    } key_t;

    // Per-template keys from A = u*h, B = v*w, D = w*h.
    function automatic key_t key_of(input logic [TPL_W-1:0] tpl,
                                    input logic [MUL_W-1:0] a,
                                    input logic [MUL_W-1:0] b,
                                    input logic [MUL_W-1:0] d);
        key_t k;
        logic signed [KEY_W-1:0] sa;
        logic signed [KEY_W-1:0] sb;
        logic signed [KEY_W-1:0] sd;
        logic signed [KEY_W-1:0] ta;
        logic signed [KEY_W-1:0] tb;
        logic signed [KEY_W-1:0] aa;
        logic signed [KEY_W-1:0] ab;
        sa = $signed(KEY_W'(a));
        sb = $signed(KEY_W'(b));
        sd = $signed(KEY_W'(d));
        ta = (sa <<< 1) - sd;
        tb = (sb <<< 1) - sd;
        aa = (ta < 0) ? -ta : ta;
        ab = (tb < 0) ? -tb : tb;
        k.k1 = '0;
        k.k2 = '0;
        case (tpl)
            TPL_THIRDS_H: k.k1 = sa;
            TPL_THIRDS_V: k.k1 = sb;
            TPL_DIAG_ANTI: k.k1 = sa + sb;
            TPL_DIAG_MAIN: k.k1 = sb - sa;
            TPL_BOX, TPL_V_0, TPL_TH_1, TPL_TT_3, TPL_TQ_3:
            begin
                k.k1 = sa;
                k.k2 = sb;
            end
            TPL_V_1, TPL_TH_3, TPL_TT_1, TPL_TQ_1:
            begin
                k.k1 = sd - sa;
                k.k2 = sb;
            end
            TPL_V_2, TPL_TH_0, TPL_TT_0, TPL_TQ_0:
            begin
                k.k1 = sb;
                k.k2 = sa;
            end
            TPL_V_3, TPL_TH_2, TPL_TT_2, TPL_TQ_2:
            begin
                k.k1 = sd - sb;
                k.k2 = sa;
            end
            TPL_BAND_0, TPL_BAND_2: k.k1 = sa + sb - sd;
            TPL_BAND_1, TPL_BAND_3: k.k1 = sb - sa;
            TPL_Y_0:
            begin
                k.k1 = sa;
                k.k2 = (sb <<< 1) - aa;
            end
            TPL_Y_1:
            begin
                k.k1 = sb;
                k.k2 = (sa <<< 1) - ab;
            end
            TPL_Y_2:
            begin
                k.k1 = sa;
                k.k2 = ((sd - sb) <<< 1) - aa;
            end
            TPL_Y_3:
            begin
                k.k1 = sb;
                k.k2 = ((sd - sa) <<< 1) - ab;
            end
            default:
            begin
                k.k1 = '0;
                k.k2 = '0;
            end
        endcase
        return k;
    endfunction

    function automatic logic [REGION_W-1:0] region_of(input logic [TPL_W-1:0] tpl,
                                                      input key_t k,
                                                      input logic [MUL_W-1:0] d);
        logic signed [CMP_W-1:0] c1;
        logic signed [CMP_W-1:0] c2;
        logic signed [CMP_W-1:0] cd;
        logic signed [CMP_W-1:0] c1x2;
        logic signed [CMP_W-1:0] c1x3;
        logic signed [CMP_W-1:0] c1x4;
        logic signed [CMP_W-1:0] c2x2;
        logic signed [CMP_W-1:0] c2x4;
        logic signed [CMP_W-1:0] dx2;
        logic signed [CMP_W-1:0] dx3;
        logic [REGION_W-1:0] half2;
        logic [REGION_W-1:0] r;
        c1   = {{(CMP_W-KEY_W){k.k1[KEY_W-1]}}, k.k1};
        c2   = {{(CMP_W-KEY_W){k.k2[KEY_W-1]}}, k.k2};
        cd   = $signed(CMP_W'(d));
        c1x2 = c1 <<< 1;
        c1x3 = c1x2 + c1;
        c1x4 = c1 <<< 2;
        c2x2 = c2 <<< 1;
        c2x4 = c2 <<< 2;
        dx2  = cd <<< 1;
        dx3  = dx2 + cd;
        half2 = (c2x2 < cd) ? REGION_1 : REGION_2;
        case (tpl)
            TPL_UNIFORM: r = REGION_0;
            TPL_THIRDS_H, TPL_THIRDS_V:
                r = (c1x3 < cd) ? REGION_0 : ((c1x3 < dx2) ? REGION_1 : REGION_2);
            TPL_DIAG_ANTI: r = (c1 < cd) ? REGION_0 : REGION_1;
            TPL_DIAG_MAIN: r = (c1 < 0) ? REGION_0 : REGION_1;
            TPL_BOX:
                r = (c1x4 > cd && c1x4 < dx3 && c2x4 > cd && c2x4 < dx3) ?
                    REGION_1 : REGION_0;
            TPL_V_0, TPL_V_1, TPL_V_2, TPL_V_3:
                r = REGION_W'(c2x2 - c1 >= 0) + REGION_W'(c2x2 + c1 >= dx2);
            TPL_BAND_0, TPL_BAND_1:
                r = REGION_W'(c1x2 >= -cd) + REGION_W'(c1x2 >= cd);
            TPL_BAND_2, TPL_BAND_3:
                r = REGION_W'(c1x4 >= -cd) + REGION_W'(c1x4 >= cd);
            TPL_Y_0, TPL_Y_1, TPL_Y_2, TPL_Y_3:
                r = (c2 <= cd) ? ((c1x2 < cd) ? REGION_1 : REGION_2) : REGION_0;
            TPL_TH_0, TPL_TH_1, TPL_TH_2, TPL_TH_3:
                r = (c1x2 >= cd) ? half2 : REGION_0;
            TPL_TT_0, TPL_TT_1, TPL_TT_2, TPL_TT_3:
                r = (c1x3 >= dx2) ? half2 : REGION_0;
            TPL_TQ_0, TPL_TQ_1, TPL_TQ_2, TPL_TQ_3:
                r = (c1x4 >= cd) ? half2 : REGION_0;
            default: r = REGION_0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/stl_if.sv
interface stl_pos_if;
    logic                        valid;
    logic                        ready;
    logic [stl_pkg::POS_W-1:0]   pos_x;
    logic [stl_pkg::POS_W-1:0]   pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface stl_label_if;
    logic                          valid;
    logic                          ready;
    logic [stl_pkg::LABEL_W-1:0]   label;
    logic [stl_pkg::REGION_W-1:0]  region;
    logic                          outside;

    modport source (output valid, output label, output region, output outside, input ready);
    modport sink   (input valid, input label, input region, input outside, output ready);
endinterface

>>> hw/rtl/segmentation_template_labeler_core.sv
// Segmentation template labeler.
// pix (sink): one pixel position per transaction, pos_x and pos_y.
// res (source): one result per position, label, region and outside flag,
//   in the order the positions were taken.
// cfg_we/cfg_index/cfg_wdata: register writes, one per cycle; the user must write
//   them only while no position is in flight, which the block itself leaves unchecked.
// Five register stages: window check and offset, three multipliers
//   (u*h, v*w, w*h), template keys, region compare, label select.
// Throughput: one position per cycle while res.ready holds; every stage is a single register.
// A stalled stage holds its item; pix.ready drops only when all five
//   stages are full and res.ready is low, so nothing is lost or repeated.
// Reset clears all stage valid bits and loads the register defaults
//   (rectangle at 0,0 of size 1x1, template 0, labels 0, 1, 2).
// Positions outside the rectangle give label 255, region 0, outside 1.
module segmentation_template_labeler_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [stl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    stl_pos_if.sink                         pix,
    stl_label_if.source                     res
);

    stl_pkg::cfg_t cfg;

    stl_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

    logic                               s1_out_reg;
    logic [stl_pkg::POS_W-1:0]          s1_u_reg;
    logic [stl_pkg::POS_W-1:0]          s1_v_reg;
    logic                               s2_out_reg;
    logic [stl_pkg::MUL_W-1:0]          s2_a_reg;
    logic [stl_pkg::MUL_W-1:0]          s2_b_reg;
    logic [stl_pkg::MUL_W-1:0]          s2_d_reg;
    logic                               s3_out_reg;
    stl_pkg::key_t                      s3_key_reg;
    logic [stl_pkg::MUL_W-1:0]          s3_d_reg;
    logic                               s4_out_reg;
    logic [stl_pkg::REGION_W-1:0]       s4_region_reg;
    logic                               s5_out_reg;
    logic [stl_pkg::LABEL_W-1:0]        s5_label_reg;
    logic [stl_pkg::REGION_W-1:0]       s5_region_reg;

    logic [stl_pkg::POS_W:0]            x_end;
    logic [stl_pkg::POS_W:0]            y_end;
    logic                               in_rect;
    logic [stl_pkg::POS_W-1:0]          u_next;
    logic [stl_pkg::POS_W-1:0]          v_next;
    logic [stl_pkg::LABEL_W-1:0]        label_next;

    assign s5_ready  = !s5_valid_reg || res.ready;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pix.ready = s1_ready;

    // Half-open window test.
    assign x_end   = (stl_pkg::POS_W+1)'(cfg.left) + (stl_pkg::POS_W+1)'(cfg.width);
    assign y_end   = (stl_pkg::POS_W+1)'(cfg.top) + (stl_pkg::POS_W+1)'(cfg.height);
    assign in_rect = (pix.pos_x >= stl_pkg::POS_W'(cfg.left))
                  && ((stl_pkg::POS_W+1)'(pix.pos_x) < x_end)
                  && (pix.pos_y >= stl_pkg::POS_W'(cfg.top))
                  && ((stl_pkg::POS_W+1)'(pix.pos_y) < y_end);
    assign u_next  = pix.pos_x - stl_pkg::POS_W'(cfg.left);
    assign v_next  = pix.pos_y - stl_pkg::POS_W'(cfg.top);

    always_comb
    begin
        case (s4_region_reg)
            stl_pkg::REGION_0: label_next = cfg.lab0;
            stl_pkg::REGION_1: label_next = cfg.lab1;
            default:           label_next = cfg.lab2;
        endcase
        if (s4_out_reg)
        begin
            label_next = stl_pkg::LABEL_OUTSIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pix.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pix.valid)
        begin
            s1_out_reg <= !in_rect;
            s1_u_reg   <= u_next;
            s1_v_reg   <= v_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_out_reg <= s1_out_reg;
            s2_a_reg   <= stl_pkg::MUL_W'(s1_u_reg) * stl_pkg::MUL_W'(cfg.height);
            s2_b_reg   <= stl_pkg::MUL_W'(s1_v_reg) * stl_pkg::MUL_W'(cfg.width);
            s2_d_reg   <= stl_pkg::MUL_W'(cfg.width) * stl_pkg::MUL_W'(cfg.height);
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_out_reg <= s2_out_reg;
            s3_key_reg <= stl_pkg::key_of(cfg.tpl, s2_a_reg, s2_b_reg, s2_d_reg);
            s3_d_reg   <= s2_d_reg;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_out_reg    <= s3_out_reg;
            s4_region_reg <= s3_out_reg ? stl_pkg::REGION_0
                           : stl_pkg::region_of(cfg.tpl, s3_key_reg, s3_d_reg);
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_out_reg    <= s4_out_reg;
            s5_label_reg  <= label_next;
            s5_region_reg <= s4_region_reg;
        end
    end

    assign res.valid   = s5_valid_reg;
    assign res.label   = s5_label_reg;
    assign res.region  = s5_region_reg;
    assign res.outside = s5_out_reg;

endmodule

>>> hw/rtl/stl_regfile.sv
module stl_regfile
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [stl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output stl_pkg::cfg_t                      cfg
);

    stl_pkg::cfg_t cfg_reg;
    stl_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                stl_pkg::REG_AREA_LEFT:
                    cfg_next.left = cfg_wdata[stl_pkg::ORG_W-1:0];
                stl_pkg::REG_AREA_TOP:
                    cfg_next.top = cfg_wdata[stl_pkg::ORG_W-1:0];
                stl_pkg::REG_AREA_WIDTH:
                    cfg_next.width = cfg_wdata[stl_pkg::SIZE_W-1:0];
                stl_pkg::REG_AREA_HEIGHT:
                    cfg_next.height = cfg_wdata[stl_pkg::SIZE_W-1:0];
                stl_pkg::REG_TEMPLATE_INDEX:
                    cfg_next.tpl = cfg_wdata[stl_pkg::TPL_W-1:0];
                stl_pkg::REG_LABEL_REGION0:
                    cfg_next.lab0 = cfg_wdata[stl_pkg::LABEL_W-1:0];
                stl_pkg::REG_LABEL_REGION1:
                    cfg_next.lab1 = cfg_wdata[stl_pkg::LABEL_W-1:0];
                stl_pkg::REG_LABEL_REGION2:
                    cfg_next.lab2 = cfg_wdata[stl_pkg::LABEL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left   <= '0;
            cfg_reg.top    <= '0;
            cfg_reg.width  <= stl_pkg::SIZE_W'(1);
            cfg_reg.height <= stl_pkg::SIZE_W'(1);
            cfg_reg.tpl    <= stl_pkg::TPL_UNIFORM;
            cfg_reg.lab0   <= stl_pkg::LABEL_W'(0);
            cfg_reg.lab1   <= stl_pkg::LABEL_W'(1);
            cfg_reg.lab2   <= stl_pkg::LABEL_W'(2);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/stl_checker.sv
`include "segmentation_template_labeler_core_defines.svh"

module stl_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           pix_ready,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [stl_pkg::LABEL_W-1:0]    res_label,
    input logic [stl_pkg::REGION_W-1:0]   res_region,
    input logic                           res_outside
);

    `STL_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_label) && $stable(res_region) && $stable(res_outside), "stalled result changed")
    `STL_ASSERT_IMPL(a_outside_fmt, clk, rst_n, res_valid && res_outside, res_label == stl_pkg::LABEL_OUTSIDE && res_region == stl_pkg::REGION_0, "outside result malformed")
    `STL_ASSERT_IMPL(a_region_range, clk, rst_n, res_valid, res_region <= stl_pkg::REGION_2, "region out of range")
    `STL_ASSERT_IMPL(a_full_stall, clk, rst_n, !pix_ready, res_valid && !res_ready, "input blocked while output free")

endmodule

bind segmentation_template_labeler_core stl_checker u_stl_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_ready   (pix.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_label   (res.label),
    .res_region  (res.region),
    .res_outside (res.outside)
);

>>> tb/tb_segmentation_template_labeler_core.sv
module tb_segmentation_template_labeler_core;
    import stl_pkg::*;

    typedef struct packed {
        logic [LABEL_W-1:0]  label;
        logic [REGION_W-1:0] region;
        logic                outside;
    } label_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    stl_pos_if   pix_bus ();
    stl_label_if res_bus ();

    segmentation_template_labeler_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pix       (pix_bus),
        .res       (res_bus)
    );

    cfg_t          area_cfg;
    label_result_t expected_labels[$];
    int            mismatches;
    bit            gapless;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint magnitude(input longint a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic logic [REGION_W-1:0] template_region(input logic [TPL_W-1:0] tpl,
                                                            input longint a,
                                                            input longint b,
                                                            input longint d);
        longint k1;
        longint k2;
        longint l1;
        longint l2;
        k1 = 0;
        k2 = 0;
        case (tpl)
            TPL_UNIFORM: return REGION_0;
            TPL_THIRDS_H: return REGION_W'((3 * a) / d);
            TPL_THIRDS_V: return REGION_W'((3 * b) / d);
            TPL_DIAG_ANTI: return (a + b < d) ? REGION_0 : REGION_1;
            TPL_DIAG_MAIN: return (b < a) ? REGION_0 : REGION_1;
            TPL_BOX:
            begin
                l1 = (magnitude(4 * a - 2 * d) < d) ? 1 : 0;
                l2 = (magnitude(4 * b - 2 * d) < d) ? 1 : 0;
                return REGION_W'(l1 * l2);
            end
            TPL_V_0, TPL_V_1, TPL_V_2, TPL_V_3:
            begin
                case (tpl)
                    TPL_V_0:
                    begin
                        k1 = a;
                        k2 = b;
                    end
                    TPL_V_1:
                    begin
                        k1 = d - a;
                        k2 = b;
                    end
                    TPL_V_2:
                    begin
                        k1 = b;
                        k2 = a;
                    end
                    default:
                    begin
                        k1 = d - b;
                        k2 = a;
                    end
                endcase
                l1 = (2 * k2 - k1 < 0) ? 0 : 1;
                l2 = (2 * k2 - 2 * d + k1 < 0) ? 0 : 1;
                return REGION_W'(l1 + l2);
            end
            TPL_BAND_0, TPL_BAND_1, TPL_BAND_2, TPL_BAND_3:
            begin
                k1 = (tpl == TPL_BAND_0 || tpl == TPL_BAND_2) ? (a + b - d) : (b - a);
                if (tpl <= TPL_BAND_1)
                begin
                    l1 = (2 * k1 < -d) ? 0 : 1;
                    l2 = (2 * k1 < d) ? 0 : 1;
                end
                else
                begin
                    l1 = (4 * k1 < -d) ? 0 : 1;
                    l2 = (4 * k1 < d) ? 0 : 1;
                end
                return REGION_W'(l1 + l2);
            end
            TPL_Y_0, TPL_Y_1, TPL_Y_2, TPL_Y_3:
            begin
                // k2 is twice the distance key
                case (tpl)
                    TPL_Y_0:
                    begin
                        k1 = a;
                        k2 = 2 * b - magnitude(2 * a - d);
                    end
                    TPL_Y_1:
                    begin
                        k1 = b;
                        k2 = 2 * a - magnitude(2 * b - d);
                    end
                    TPL_Y_2:
                    begin
                        k1 = a;
                        k2 = 2 * (d - b) - magnitude(2 * a - d);
                    end
                    default:
                    begin
                        k1 = b;
                        k2 = 2 * (d - a) - magnitude(2 * b - d);
                    end
                endcase
                l1 = (k2 > d) ? 0 : 1;
                l2 = (2 * k1 < d) ? 1 : 2;
                return REGION_W'(l1 * l2);
            end
            TPL_TH_0, TPL_TT_0, TPL_TQ_0:
            begin
                k1 = b;
                k2 = a;
            end
            TPL_TH_1, TPL_TT_3, TPL_TQ_3:
            begin
                k1 = a;
                k2 = b;
            end
            TPL_TH_2, TPL_TT_2, TPL_TQ_2:
            begin
                k1 = d - b;
                k2 = a;
            end
            TPL_TH_3, TPL_TT_1, TPL_TQ_1:
            begin
                k1 = d - a;
                k2 = b;
            end
            default: return REGION_0;
        endcase
        l2 = (2 * k2 < d) ? 1 : 2;
        if (tpl <= TPL_TH_3)
            l1 = (2 * k1 < d) ? 0 : 1;
        else if (tpl <= TPL_TT_3)
            l1 = (3 * k1 < 2 * d) ? 0 : 1;
        else
            l1 = (4 * k1 < d) ? 0 : 1;
        return REGION_W'(l1 * l2);
    endfunction

    function automatic label_result_t predict_label(input logic [POS_W-1:0] x,
                                                    input logic [POS_W-1:0] y);
        label_result_t r;
        longint px;
        longint py;
        longint lx;
        longint ly;
        longint w;
        longint h;
        px = longint'(x);
        py = longint'(y);
        lx = longint'(area_cfg.left);
        ly = longint'(area_cfg.top);
        w  = longint'(area_cfg.width);
        h  = longint'(area_cfg.height);
        if (px < lx || px >= lx + w || py < ly || py >= ly + h)
        begin
            r.label   = LABEL_OUTSIDE;
            r.region  = REGION_0;
            r.outside = 1'b1;
        end
        else
        begin
            r.region  = template_region(area_cfg.tpl, (px - lx) * h, (py - ly) * w, w * h);
            r.outside = 1'b0;
            case (r.region)
                REGION_0: r.label = area_cfg.lab0;
                REGION_1: r.label = area_cfg.lab1;
                default:  r.label = area_cfg.lab2;
            endcase
        end
        return r;
    endfunction

    // receiver backpressure
    initial
    begin
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_bus.ready <= gapless || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk)
    begin
        label_result_t want;
        if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (expected_labels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: label %0d region %0d outside %0b",
                             res_bus.label, res_bus.region, res_bus.outside);
            end
            else
            begin
                want = expected_labels.pop_front();
                if (res_bus.label !== want.label || res_bus.region !== want.region ||
                    res_bus.outside !== want.outside)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: label %0d/%0d region %0d/%0d outside %0b/%0b (exp/got)",
                                 want.label, res_bus.label, want.region, res_bus.region,
                                 want.outside, res_bus.outside);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_AREA_LEFT:      area_cfg.left   = value[ORG_W-1:0];
            REG_AREA_TOP:       area_cfg.top    = value[ORG_W-1:0];
            REG_AREA_WIDTH:     area_cfg.width  = value;
            REG_AREA_HEIGHT:    area_cfg.height = value;
            REG_TEMPLATE_INDEX: area_cfg.tpl    = value[TPL_W-1:0];
            REG_LABEL_REGION0:  area_cfg.lab0   = value[LABEL_W-1:0];
            REG_LABEL_REGION1:  area_cfg.lab1   = value[LABEL_W-1:0];
            default:            area_cfg.lab2   = value[LABEL_W-1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic set_area(input logic [CFG_DATA_W-1:0] left, top, width, height,
                            input logic [CFG_DATA_W-1:0] tpl, lab0, lab1, lab2);
        write_reg(REG_AREA_LEFT, left);
        write_reg(REG_AREA_TOP, top);
        write_reg(REG_AREA_WIDTH, width);
        write_reg(REG_AREA_HEIGHT, height);
        write_reg(REG_TEMPLATE_INDEX, tpl);
        write_reg(REG_LABEL_REGION0, lab0);
        write_reg(REG_LABEL_REGION1, lab1);
        write_reg(REG_LABEL_REGION2, lab2);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pos(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        while (!gapless && $urandom_range(99) < 27)
        begin
            pix_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pos_x <= x;
        pix_bus.pos_y <= y;
        @(posedge clk);
        while (pix_bus.ready !== 1'b1)
            @(posedge clk);
        expected_labels = {expected_labels, predict_label(x, y)};
    endtask

    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (expected_labels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_pos(0, 0);
        send_pos(1, 0);
        send_pos(0, 1);
        wait_idle();
    endtask

    task automatic test_window_edges();
        set_area(100, 200, 50, 30, CFG_DATA_W'(TPL_UNIFORM), 255, 3, 4);
        send_pos(99, 200);
        send_pos(100, 200);
        send_pos(149, 229);
        send_pos(150, 229);
        send_pos(100, 230);
        send_pos(100, 199);
        wait_idle();
        // origin at the top, size beyond the coordinate range
        set_area(4095, 4095, 8191, 8191, CFG_DATA_W'(TPL_THIRDS_H), 10, 20, 30);
        send_pos(8191, 8191);
        send_pos(4094, 8191);
        send_pos(0, 0);
        wait_idle();
        set_area(0, 0, 0, 10, CFG_DATA_W'(TPL_UNIFORM), 1, 2, 3);
        send_pos(0, 0);
        wait_idle();
        set_area(0, 0, 10, 0, CFG_DATA_W'(TPL_UNIFORM), 1, 2, 3);
        send_pos(0, 0);
        wait_idle();
    endtask

    task automatic test_undefined_templates();
        set_area(0, 0, 8, 8, CFG_DATA_W'(TPL_TQ_3 + 1), 7, 8, 9);
        send_pos(7, 7);
        wait_idle();
        set_area(0, 0, 8, 8, CFG_DATA_W'(TPL_TQ_3 + 2), 7, 8, 9);
        send_pos(7, 7);
        wait_idle();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(9))
            0: return CFG_DATA_W'($urandom_range(1, 4));
            6: return CFG_DATA_W'($urandom_range(1, 4096));
            7:
            begin
                case ($urandom_range(3))
                    0: return 0;
                    1: return 1;
                    2: return 4096;
                    default: return 8191;
                endcase
            end
            8: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_coord(input int org, input int size);
        int r;
        r = $urandom_range(99);
        if (r < 10 || size == 0)
            return POS_W'($urandom);
        if (r < 25)
        begin
            case ($urandom_range(3))
                0: return POS_W'(org - 1);
                1: return POS_W'(org);
                2: return POS_W'(org + size - 1);
                default: return POS_W'(org + size);
            endcase
        end
        return POS_W'(org + $urandom_range(size - 1));
    endfunction

    task automatic test_random_areas();
        int phase;
        int n;
        logic [CFG_DATA_W-1:0] left;
        logic [CFG_DATA_W-1:0] top;
        logic [CFG_DATA_W-1:0] tpl;
        for (phase = 0; phase < 48; phase++)
        begin
            gapless = (phase >= 20 && phase < 26);
            left = ($urandom_range(1) == 0) ? CFG_DATA_W'($urandom_range(255))
                                            : CFG_DATA_W'($urandom);
            top  = ($urandom_range(1) == 0) ? CFG_DATA_W'($urandom_range(255))
                                            : CFG_DATA_W'($urandom);
            tpl  = (phase < 32) ? CFG_DATA_W'(phase) : CFG_DATA_W'($urandom);
            set_area(left, top, pick_size(), pick_size(), tpl,
                     CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            for (n = 0; n < 24; n++)
                send_pos(pick_coord(int'(area_cfg.left), int'(area_cfg.width)),
                         pick_coord(int'(area_cfg.top), int'(area_cfg.height)));
            wait_idle();
        end
        gapless = 1'b0;
    endtask

    initial
    begin
        mismatches = 0;
        gapless    = 1'b0;
        area_cfg   = '{left: 0, top: 0, width: 1, height: 1, tpl: TPL_UNIFORM,
                       lab0: 0, lab1: 1, lab2: 2};
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_AREA_LEFT;
        cfg_wdata     <= '0;
        pix_bus.valid <= 1'b0;
        pix_bus.pos_x <= '0;
        pix_bus.pos_y <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_window_edges();
        test_undefined_templates();
        test_random_areas();
        wait_idle();
        mismatches += expected_labels.size();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
